// ===== rtl/atrlc_pkg.sv =====
package atrlc_pkg;

    localparam int LINE_CHARS = 64;
    localparam int DATA_CHARS = 64;
    localparam int CMD_CHARS  = 64;

    localparam int LINE_AW = $clog2(LINE_CHARS);
    localparam int DATA_AW = $clog2(DATA_CHARS);
    localparam int CMD_AW  = $clog2(CMD_CHARS);
    localparam int CNT_W   = (CMD_AW > DATA_AW) ? CMD_AW : DATA_AW;
    localparam int CMP_W   = 9;

    localparam int OPCODE_W = 3;
    localparam int BYTE_W   = 8;
    localparam int TIME_W   = 32;
    localparam int INDEX_W  = 6;
    localparam int STATUS_W = 3;
    localparam int LEN_W    = 6;

    typedef enum logic [OPCODE_W-1:0] {
        OP_RESET      = 3'd0,
        OP_CMD_CHAR   = 3'd1,
        OP_WAIT_ECHO  = 3'd2,
        OP_WAIT_PLAIN = 3'd3,
        OP_RX         = 3'd4,
        OP_TIME_CHECK = 3'd5,
        OP_READ       = 3'd6
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_IDLE    = 3'd0,
        ST_PENDING = 3'd1,
        ST_OK      = 3'd2,
        ST_ERROR   = 3'd3,
        ST_PROMPT  = 3'd4,
        ST_TIMEOUT = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_ECHO,
        S_ECHO_TAIL,
        S_DECIDE,
        S_COPY,
        S_COPY_TAIL,
        S_READ,
        S_FIN
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic echo_issue;
        logic classify;
        logic copy_issue;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic line_event;
        logic echo_check;
        logic echo_last;
        logic keep;
        logic copy_last;
        logic out_free;
    } dp_status_t;

    localparam logic [BYTE_W-1:0] CHAR_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_PROMPT = 8'h3E;
    localparam logic [BYTE_W-1:0] PRINT_LO    = 8'h20;
    localparam logic [BYTE_W-1:0] PRINT_HI    = 8'h7E;

    localparam int OK_LEN    = 2;
    localparam int ERROR_LEN = 5;
    localparam int EXT_LEN   = 10;
    localparam int OK_IW     = $clog2(OK_LEN);
    localparam int ERROR_IW  = $clog2(ERROR_LEN);
    localparam int EXT_IW    = $clog2(EXT_LEN);

    localparam logic [BYTE_W-1:0] TXT_OK [OK_LEN] = '{8'h4F, 8'h4B};
    localparam logic [BYTE_W-1:0] TXT_ERROR [ERROR_LEN] =
        '{8'h45, 8'h52, 8'h52, 8'h4F, 8'h52};
    localparam logic [BYTE_W-1:0] TXT_CME [EXT_LEN] =
        '{8'h2B, 8'h43, 8'h4D, 8'h45, 8'h20, 8'h45, 8'h52, 8'h52, 8'h4F, 8'h52};
    localparam logic [BYTE_W-1:0] TXT_CMS [EXT_LEN] =
        '{8'h2B, 8'h43, 8'h4D, 8'h53, 8'h20, 8'h45, 8'h52, 8'h52, 8'h4F, 8'h52};

endpackage

// ===== rtl/atrlc_if.sv =====
interface atrlc_req_if;
    import atrlc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [OPCODE_W-1:0]   opcode;
    logic [BYTE_W-1:0]     byte_value;
    logic [TIME_W-1:0]     now_ms;
    logic [TIME_W-1:0]     wait_ms;
    logic [INDEX_W-1:0]    read_index;

    modport source (
        output valid, opcode, byte_value, now_ms, wait_ms, read_index,
        input  ready
    );

    modport sink (
        input  valid, opcode, byte_value, now_ms, wait_ms, read_index,
        output ready
    );
endinterface

interface atrlc_rsp_if;
    import atrlc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic                  byte_consumed;
    logic                  data_valid;
    logic [LEN_W-1:0]      data_length;
    logic [BYTE_W-1:0]     data_byte;
    logic                  prompt_seen;

    modport source (
        output valid, status, byte_consumed, data_valid, data_length, data_byte,
               prompt_seen,
        input  ready
    );

    modport sink (
        input  valid, status, byte_consumed, data_valid, data_length, data_byte,
               prompt_seen,
        output ready
    );
endinterface

// ===== rtl/atrlc_ram.sv =====
module atrlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/atrlc_ctrl.sv =====
module atrlc_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  atrlc_pkg::dp_status_t  status,
    output atrlc_pkg::ctrl_cmd_t   cmd
);
    import atrlc_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (status.line_event)
                begin
                    state_next = status.echo_check ? S_ECHO : S_DECIDE;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_ECHO:
            begin
                cmd.echo_issue = 1'b1;
                if (status.echo_last)
                begin
                    state_next = S_ECHO_TAIL;
                end
            end
            S_ECHO_TAIL:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.classify = 1'b1;
                state_next   = status.keep ? S_COPY : S_READ;
            end
            S_COPY:
            begin
                cmd.copy_issue = 1'b1;
                if (status.copy_last)
                begin
                    state_next = S_COPY_TAIL;
                end
            end
            S_COPY_TAIL:
            begin
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

// ===== rtl/atrlc_dp.sv =====
module atrlc_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [atrlc_pkg::OPCODE_W-1:0]   opcode,
    input  logic [atrlc_pkg::BYTE_W-1:0]     byte_value,
    input  logic [atrlc_pkg::TIME_W-1:0]     now_ms,
    input  logic [atrlc_pkg::TIME_W-1:0]     wait_ms,
    input  logic [atrlc_pkg::INDEX_W-1:0]    read_index,
    input  atrlc_pkg::ctrl_cmd_t             cmd,
    output atrlc_pkg::dp_status_t            status,
    output logic                             resp_valid,
    input  logic                             resp_ready,
    output logic [atrlc_pkg::STATUS_W-1:0]   resp_status,
    output logic                             resp_consumed,
    output logic                             resp_data_valid,
    output logic [atrlc_pkg::LEN_W-1:0]      resp_data_length,
    output logic [atrlc_pkg::BYTE_W-1:0]     resp_data_byte,
    output logic                             resp_prompt
);
    import atrlc_pkg::*;

    // captured item
    opcode_t             op_reg;
    logic [BYTE_W-1:0]   byte_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [TIME_W-1:0]   tmo_reg;
    logic [INDEX_W-1:0]  idx_reg;

    status_t             status_reg,     status_next;
    logic [LINE_AW-1:0]  line_len_reg,   line_len_next;
    logic [CMD_AW-1:0]   cmd_len_reg,    cmd_len_next;
    logic [DATA_AW-1:0]  data_len_reg,   data_len_next;
    logic                data_flag_reg,  data_flag_next;
    logic                prompt_reg,     prompt_next;
    logic [TIME_W-1:0]   start_reg,      start_next;
    logic [TIME_W-1:0]   limit_reg,      limit_next;
    logic [BYTE_W-1:0]   first_reg,      first_next;
    logic                ok_m_reg,       ok_m_next;
    logic                err_m_reg,      err_m_next;
    logic                cme_m_reg,      cme_m_next;
    logic                cms_m_reg,      cms_m_next;
    logic                consumed_reg,   consumed_next;
    logic                eq_reg,         eq_next;
    logic [CNT_W-1:0]    cnt_reg,        cnt_next;
    logic                echo_pend_reg;
    logic                copy_pend_reg;
    logic [CNT_W-1:0]    copy_addr_reg;

    logic                out_valid_reg,  out_valid_next;
    status_t             out_status_reg;
    logic                out_consumed_reg;
    logic                out_dvalid_reg;
    logic [LEN_W-1:0]    out_dlen_reg;
    logic [BYTE_W-1:0]   out_dbyte_reg;
    logic                out_prompt_reg;

    logic                line_we;
    logic                cmd_we;
    logic [BYTE_W-1:0]   line_rd;
    logic [BYTE_W-1:0]   cmd_rd;
    logic [BYTE_W-1:0]   data_rd;

    logic                pending;
    logic                printable;
    logic                is_ok;
    logic                is_err;
    logic                is_prompt;
    logic                keep_req;
    logic                timed_out;
    logic [TIME_W-1:0]   elapsed;
    logic [DATA_AW-1:0]  keep_len;

    atrlc_ram #(.WIDTH(BYTE_W), .DEPTH(LINE_CHARS)) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (line_len_reg),
        .wdata (byte_reg),
        .raddr (LINE_AW'(cnt_reg)),
        .rdata (line_rd)
    );

    atrlc_ram #(.WIDTH(BYTE_W), .DEPTH(CMD_CHARS)) u_cmd_ram (
        .clk   (clk),
        .we    (cmd_we),
        .waddr (cmd_len_reg),
        .wdata (byte_reg),
        .raddr (CMD_AW'(cnt_reg)),
        .rdata (cmd_rd)
    );

    atrlc_ram #(.WIDTH(BYTE_W), .DEPTH(DATA_CHARS)) u_data_ram (
        .clk   (clk),
        .we    (copy_pend_reg),
        .waddr (DATA_AW'(copy_addr_reg)),
        .wdata (line_rd),
        .raddr (DATA_AW'(idx_reg)),
        .rdata (data_rd)
    );

    assign pending   = (status_reg == ST_PENDING);
    assign printable = byte_reg inside {[PRINT_LO:PRINT_HI]};
    assign elapsed   = now_reg - start_reg;
    assign timed_out = (elapsed >= limit_reg);

    assign line_we = cmd.exec && (op_reg == OP_RX) && pending && (byte_reg != CHAR_LF)
                     && printable && (line_len_reg != LINE_AW'(LINE_CHARS - 1));
    assign cmd_we  = cmd.exec && (op_reg == OP_CMD_CHAR) && (byte_reg != '0)
                     && (cmd_len_reg != CMD_AW'(CMD_CHARS - 1));

    assign is_ok     = (line_len_reg == LINE_AW'(OK_LEN)) && ok_m_reg;
    assign is_err    = ((line_len_reg == LINE_AW'(ERROR_LEN)) && err_m_reg)
                       || ((CMP_W'(line_len_reg) >= CMP_W'(EXT_LEN))
                           && (cme_m_reg || cms_m_reg));
    assign is_prompt = (first_reg == CHAR_PROMPT);
    assign keep_req  = !eq_reg && !is_ok && (is_err || !is_prompt);
    assign keep_len  = (CMP_W'(line_len_reg) > CMP_W'(DATA_CHARS - 1))
                       ? DATA_AW'(DATA_CHARS - 1) : DATA_AW'(line_len_reg);

    assign status.line_event = (op_reg == OP_RX) && pending && (byte_reg == CHAR_LF)
                               && (line_len_reg != '0);
    assign status.echo_check = (cmd_len_reg != '0)
                               && (CMP_W'(line_len_reg) >= CMP_W'(cmd_len_reg));
    assign status.echo_last  = (cnt_reg == CNT_W'(cmd_len_reg) - CNT_W'(1));
    assign status.keep       = keep_req && !data_flag_reg;
    assign status.copy_last  = (cnt_reg == CNT_W'(data_len_reg) - CNT_W'(1));
    assign status.out_free   = !out_valid_reg || resp_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= opcode_t'(opcode);
            byte_reg <= byte_value;
            now_reg  <= now_ms;
            tmo_reg  <= wait_ms;
            idx_reg  <= read_index;
        end
        copy_addr_reg <= cnt_reg;
        if (cmd.load_out)
        begin
            out_status_reg   <= status_reg;
            out_consumed_reg <= consumed_reg;
            out_dvalid_reg   <= data_flag_reg;
            out_dlen_reg     <= LEN_W'(data_len_reg);
            out_dbyte_reg    <= (CMP_W'(idx_reg) < CMP_W'(data_len_reg)) ? data_rd : '0;
            out_prompt_reg   <= prompt_reg;
        end
    end

    always_comb
    begin
        status_next    = status_reg;
        line_len_next  = line_len_reg;
        cmd_len_next   = cmd_len_reg;
        data_len_next  = data_len_reg;
        data_flag_next = data_flag_reg;
        prompt_next    = prompt_reg;
        start_next     = start_reg;
        limit_next     = limit_reg;
        first_next     = first_reg;
        ok_m_next      = ok_m_reg;
        err_m_next     = err_m_reg;
        cme_m_next     = cme_m_reg;
        cms_m_next     = cms_m_reg;
        consumed_next  = consumed_reg;
        eq_next        = eq_reg;
        cnt_next       = cnt_reg;

        if (cmd.exec)
        begin
            consumed_next = (op_reg == OP_RX) && pending;
            case (op_reg)
                OP_RESET:
                begin
                    status_next    = ST_IDLE;
                    line_len_next  = '0;
                    cmd_len_next   = '0;
                    data_len_next  = '0;
                    data_flag_next = 1'b0;
                    prompt_next    = 1'b0;
                    start_next     = '0;
                    limit_next     = '0;
                end
                OP_CMD_CHAR:
                begin
                    if (cmd_we)
                    begin
                        cmd_len_next = cmd_len_reg + CMD_AW'(1);
                    end
                end
                OP_WAIT_ECHO, OP_WAIT_PLAIN:
                begin
                    status_next    = ST_PENDING;
                    start_next     = now_reg;
                    limit_next     = tmo_reg;
                    line_len_next  = '0;
                    data_len_next  = '0;
                    data_flag_next = 1'b0;
                    prompt_next    = 1'b0;
                    if (op_reg == OP_WAIT_PLAIN)
                    begin
                        cmd_len_next = '0;
                    end
                end
                OP_RX:
                begin
                    if (status.line_event)
                    begin
                        eq_next  = status.echo_check;
                        cnt_next = '0;
                    end
                    else if (line_we)
                    begin
                        line_len_next = line_len_reg + LINE_AW'(1);
                        if (line_len_reg == '0)
                        begin
                            first_next = byte_reg;
                        end
                        ok_m_next  = ((line_len_reg == '0) || ok_m_reg)
                            && ((CMP_W'(line_len_reg) >= CMP_W'(OK_LEN)) ? 1'b1
                                : (byte_reg == TXT_OK[line_len_reg[OK_IW-1:0]]));
                        err_m_next = ((line_len_reg == '0) || err_m_reg)
                            && ((CMP_W'(line_len_reg) >= CMP_W'(ERROR_LEN)) ? 1'b1
                                : (byte_reg == TXT_ERROR[line_len_reg[ERROR_IW-1:0]]));
                        cme_m_next = ((line_len_reg == '0) || cme_m_reg)
                            && ((CMP_W'(line_len_reg) >= CMP_W'(EXT_LEN)) ? 1'b1
                                : (byte_reg == TXT_CME[line_len_reg[EXT_IW-1:0]]));
                        cms_m_next = ((line_len_reg == '0) || cms_m_reg)
                            && ((CMP_W'(line_len_reg) >= CMP_W'(EXT_LEN)) ? 1'b1
                                : (byte_reg == TXT_CMS[line_len_reg[EXT_IW-1:0]]));
                    end
                end
                OP_TIME_CHECK:
                begin
                    if (pending)
                    begin
                        if ((line_len_reg != '0) && is_prompt)
                        begin
                            prompt_next   = 1'b1;
                            status_next   = ST_PROMPT;
                            line_len_next = '0;
                        end
                        else if (timed_out)
                        begin
                            status_next = ST_TIMEOUT;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (echo_pend_reg)
        begin
            eq_next = eq_reg && (line_rd == cmd_rd);
        end

        if (cmd.echo_issue || cmd.copy_issue)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end

        if (cmd.classify)
        begin
            line_len_next = '0;
            cnt_next      = '0;
            if (!eq_reg)
            begin
                if (is_ok)
                begin
                    status_next = ST_OK;
                end
                else if (is_err)
                begin
                    status_next = ST_ERROR;
                end
                else if (is_prompt)
                begin
                    prompt_next = 1'b1;
                    status_next = ST_PROMPT;
                end
            end
            if (status.keep)
            begin
                data_len_next  = keep_len;
                data_flag_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (resp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg    <= ST_IDLE;
            line_len_reg  <= '0;
            cmd_len_reg   <= '0;
            data_len_reg  <= '0;
            data_flag_reg <= 1'b0;
            prompt_reg    <= 1'b0;
            start_reg     <= '0;
            limit_reg     <= '0;
            first_reg     <= '0;
            ok_m_reg      <= 1'b0;
            err_m_reg     <= 1'b0;
            cme_m_reg     <= 1'b0;
            cms_m_reg     <= 1'b0;
            consumed_reg  <= 1'b0;
            eq_reg        <= 1'b0;
            cnt_reg       <= '0;
            echo_pend_reg <= 1'b0;
            copy_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            status_reg    <= status_next;
            line_len_reg  <= line_len_next;
            cmd_len_reg   <= cmd_len_next;
            data_len_reg  <= data_len_next;
            data_flag_reg <= data_flag_next;
            prompt_reg    <= prompt_next;
            start_reg     <= start_next;
            limit_reg     <= limit_next;
            first_reg     <= first_next;
            ok_m_reg      <= ok_m_next;
            err_m_reg     <= err_m_next;
            cme_m_reg     <= cme_m_next;
            cms_m_reg     <= cms_m_next;
            consumed_reg  <= consumed_next;
            eq_reg        <= eq_next;
            cnt_reg       <= cnt_next;
            echo_pend_reg <= cmd.echo_issue;
            copy_pend_reg <= cmd.copy_issue;
            out_valid_reg <= out_valid_next;
        end
    end

    assign resp_valid       = out_valid_reg;
    assign resp_status      = out_status_reg;
    assign resp_consumed    = out_consumed_reg;
    assign resp_data_valid  = out_dvalid_reg;
    assign resp_data_length = out_dlen_reg;
    assign resp_data_byte   = out_dbyte_reg;
    assign resp_prompt      = out_prompt_reg;

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || resp_ready))
        else $error("result register overwritten before transfer");

    a_consume_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && (op_reg == OP_RX) && !pending) |=> !consumed_reg)
        else $error("byte consumed while no wait pending");

    a_echo_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.echo_issue |-> (cmd_len_reg != '0))
        else $error("echo compare with empty command");

    a_copy_flagged: assert property (@(posedge clk) disable iff (!rst_n)
        copy_pend_reg |-> data_flag_reg)
        else $error("data store written without data line flag");
endmodule

// ===== rtl/at_response_line_classifier.sv =====
// Channel | Dir | Transfer when        | Payload
// req     | in  | req.valid & ready    | opcode, byte_value, now_ms, wait_ms, read_index
// resp    | out | resp.valid & ready   | status, byte_consumed, data_valid, data_length,
//         |     |                      | data_byte, prompt_seen
//
// One item at a time. An LF closing a non-empty line adds an echo compare over the
// stored command length (when the line is at least that long), a classify step and,
// when the line is stored, a line copy of the kept length: the single read port of
// the line store sets these sweeps.
// Reset clears all control state; the stores are not cleared and are only read below
// their lengths. A stalled result is held in the output register while the next
// item is taken; that item waits for the register before it completes.
module at_response_line_classifier (
    input  logic        clk,
    input  logic        rst_n,
    atrlc_req_if.sink   req,
    atrlc_rsp_if.source resp
);
    import atrlc_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;
    logic       ready;

    atrlc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (ready),
        .status    (dp_status),
        .cmd       (cmd)
    );

    atrlc_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .opcode           (req.opcode),
        .byte_value       (req.byte_value),
        .now_ms           (req.now_ms),
        .wait_ms          (req.wait_ms),
        .read_index       (req.read_index),
        .cmd              (cmd),
        .status           (dp_status),
        .resp_valid       (resp.valid),
        .resp_ready       (resp.ready),
        .resp_status      (resp.status),
        .resp_consumed    (resp.byte_consumed),
        .resp_data_valid  (resp.data_valid),
        .resp_data_length (resp.data_length),
        .resp_data_byte   (resp.data_byte),
        .resp_prompt      (resp.prompt_seen)
    );

    assign req.ready = ready;
endmodule
